// ----- hdl/aes128_block_cipher_macros.svh -----
// Assertion macros for the AES-128 block cipher.
// Both use i_clk as the clock and are switched off while i_rst_n is low.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication.
`define AES_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aes128 assertion failed");

// Next-cycle implication.
`define AES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aes128 assertion failed");

`endif

// ----- hdl/aes128_pkg.sv -----
// Constants, S-box tables and round functions for the AES-128 block cipher.
// No dependencies; used by aes128_block_cipher.
package aes128_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_BITS  = 128;
    localparam int NK        = KEY_BITS / 32;
    localparam int RK_AW     = $clog2(ROUNDS + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 2'd2;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1B;

    typedef logic [255:0][7:0] t_sbox_table;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Inverse table, built at elaboration by inverting the forward table.
    function automatic t_sbox_table f_make_inv_sbox();
        t_sbox_table t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam t_sbox_table INV_SBOX = f_make_inv_sbox();

    function automatic logic [7:0] f_xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] f_mix_word(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {f_xt(a0) ^ f_xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ f_xt(a1) ^ f_xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ f_xt(a2) ^ f_xt(a3) ^ a3,
                f_xt(a0) ^ a0 ^ a1 ^ a2 ^ f_xt(a3)};
    endfunction

    function automatic logic [31:0] f_inv_mix_word(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int i = 0; i < 4; i++) begin
            a[i]   = w[31-8*i -: 8];
            x2     = f_xt(a[i]);
            x4     = f_xt(x2);
            x8     = f_xt(x4);
            m9[i]  = x8 ^ a[i];
            m11[i] = x8 ^ x2 ^ a[i];
            m13[i] = x8 ^ x4 ^ a[i];
            m14[i] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
    endfunction

    // SubBytes + ShiftRows, or their inverses. Byte 0 is the MSB of the state.
    function automatic logic [127:0] f_sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   v;
        int           src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                v   = s[127-8*(4*src+r) -: 8];
                t[127-8*(4*c+r) -: 8] = inv ? INV_SBOX[v] : SBOX[v];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] f_mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = inv ? f_inv_mix_word(s[127-32*c -: 32])
                                    : f_mix_word(s[127-32*c -: 32]);
        end
        return t;
    endfunction

    // One step of the key schedule: round key i-1 to round key i.
    function automatic logic [127:0] f_key_next(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ f_sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h000000};
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- hdl/aes128_block_cipher.sv -----
// AES-128 block cipher: key schedule sequencer and one shared round unit.
// Depends on aes128_pkg and aes128_block_cipher_macros.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    128-bit plaintext/ciphertext block
//  m_axis    out  m_axis_tvalid/m_axis_tready    128-bit result block
//  cfg       in   i_cfg_valid/o_cfg_ready        register index and 64-bit data
//
// A block gets the initial key addition on the accept edge, then one
// round per cycle through the single round unit (10 rounds).
// Reset and every accepted register write (index 0..2) start a key
// expansion into the 11-entry round key file; inputs and config wait meanwhile.
// The result sits in an output register, so a new block may enter while it waits;
// a finished block is held in the state register until the output frees.
`include "aes128_block_cipher_macros.svh"

module aes128_block_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [63:0] block_high, [127:64] block_low
    input  logic [127:0]                        s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [63:0] result_high, [127:64] result_low
    output logic [127:0]                        m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aes128_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);
    import aes128_pkg::*;

    typedef enum logic [1:0] {
        S_EXPAND,
        S_IDLE,
        S_ROUND,
        S_HOLD
    } t_fsm;

    localparam logic [RK_AW-1:0] LAST_RK = RK_AW'(ROUNDS);

    t_fsm             r_fsm, n_fsm;
    logic [63:0]      r_key_high, n_key_high;
    logic [63:0]      r_key_low, n_key_low;
    logic             r_decrypt, n_decrypt;
    logic [127:0]     r_kexp, n_kexp;
    logic [7:0]       r_rcon, n_rcon;
    logic [RK_AW-1:0] r_cnt, n_cnt;
    logic [127:0]     r_state, n_state;
    logic [127:0]     r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [127:0]     r_rk [ROUNDS+1];

    logic             in_fire, cfg_fire, out_free, cnt_last;
    logic [RK_AW-1:0] rk_addr;
    logic [127:0]     rk_rd, rk_wr;
    logic [127:0]     sub_out, mix_out, round_out;

    assign s_axis_tready = (r_fsm == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_fsm == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cnt_last = (r_cnt == LAST_RK);

    // Decryption walks the key file backwards.
    always_comb begin
        if (r_fsm == S_IDLE) begin
            rk_addr = r_decrypt ? LAST_RK : '0;
        end else begin
            rk_addr = r_decrypt ? (LAST_RK - r_cnt) : r_cnt;
        end
    end

    assign rk_rd     = r_rk[rk_addr];
    assign sub_out   = f_sub_shift(r_state, r_decrypt);
    assign mix_out   = cnt_last ? sub_out : f_mix(sub_out, r_decrypt);
    assign round_out = mix_out ^ rk_rd;

    // Middle round keys of the equivalent inverse cipher get InvMixColumns.
    assign rk_wr = (r_decrypt && (r_cnt != '0) && !cnt_last) ? f_mix(r_kexp, 1'b1) : r_kexp;

    always_comb begin
        n_fsm       = r_fsm;
        n_key_high  = r_key_high;
        n_key_low   = r_key_low;
        n_decrypt   = r_decrypt;
        n_kexp      = r_kexp;
        n_rcon      = r_rcon;
        n_cnt       = r_cnt;
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_fsm)
            S_EXPAND: begin
                n_kexp = f_key_next(r_kexp, r_rcon);
                n_rcon = f_xt(r_rcon);
                if (cnt_last) begin
                    n_cnt = '0;
                    n_fsm = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (cfg_fire) begin
                    unique case (i_cfg_index)
                        CFG_KEY_HIGH: n_key_high = i_cfg_data;
                        CFG_KEY_LOW:  n_key_low  = i_cfg_data;
                        CFG_DECRYPT:  n_decrypt  = i_cfg_data[0];
                        default: ;
                    endcase
                    if (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW ||
                        i_cfg_index == CFG_DECRYPT) begin
                        n_kexp = {n_key_high, n_key_low};
                        n_rcon = RCON_INIT;
                        n_cnt  = '0;
                        n_fsm  = S_EXPAND;
                    end
                end else if (in_fire) begin
                    n_state = {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ rk_rd;
                    n_cnt   = RK_AW'(1);
                    n_fsm   = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = round_out;
                if (cnt_last) begin
                    n_cnt = '0;
                    if (out_free) begin
                        n_out       = round_out;
                        n_out_valid = 1'b1;
                        n_fsm       = S_IDLE;
                    end else begin
                        n_fsm = S_HOLD;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_state;
                    n_out_valid = 1'b1;
                    n_fsm       = S_IDLE;
                end
            end
            default: n_fsm = S_EXPAND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_EXPAND;
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_decrypt   <= 1'b0;
            r_kexp      <= '0;
            r_rcon      <= RCON_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_key_high  <= n_key_high;
            r_key_low   <= n_key_low;
            r_decrypt   <= n_decrypt;
            r_kexp      <= n_kexp;
            r_rcon      <= n_rcon;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_state <= n_state;
        r_out   <= n_out;
    end

    // Round key file, filled one entry per cycle during expansion.
    always_ff @(posedge i_clk) begin
        if (r_fsm == S_EXPAND) begin
            r_rk[r_cnt] <= rk_wr;
        end
    end

    `AES_ASSERT_NEXT(a_accept_starts_rounds, in_fire, r_fsm == S_ROUND && r_cnt == RK_AW'(1))
    `AES_ASSERT_NEXT(a_cfg_starts_expand,
        cfg_fire && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW ||
                     i_cfg_index == CFG_DECRYPT),
        r_fsm == S_EXPAND && r_cnt == '0)
    `AES_ASSERT_IMPL(a_round_cnt_range, r_fsm == S_ROUND, r_cnt != '0 && r_cnt <= LAST_RK)
    `AES_ASSERT_IMPL(a_busy_not_ready, r_fsm != S_IDLE, !s_axis_tready && !o_cfg_ready)
    `AES_ASSERT_NEXT(a_hold_waits_output, r_fsm == S_HOLD && r_out_valid && !m_axis_tready,
        r_fsm == S_HOLD && r_out_valid)

endmodule

// ----- bench/aes128_block_cipher_tb.sv -----
// Self-checking bench for aes128_block_cipher: directed FIPS-197 rows, then random blocks
// under several key/mode settings and handshake idling patterns, checked by an in-bench AES.
// Depends on aes128_pkg and the RTL under hdl/.
module aes128_block_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes128_pkg::*;

    localparam int NWORDS      = 4 * (ROUNDS + 1);
    localparam int RESET_CYC   = 11;
    localparam int SETTLE_CYC  = 16;
    localparam int HOLD_CYC    = 300;
    localparam int WDOG_LIMIT  = 2000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [63:0] MODE_ENCRYPT = 64'd0;
    localparam logic [63:0] MODE_DECRYPT = 64'd1;
    localparam logic [7:0]  AFFINE_C     = 8'h63;
    localparam logic [7:0]  MIX_FWD [4]  = '{8'h02, 8'h03, 8'h01, 8'h01};
    localparam logic [7:0]  MIX_INV [4]  = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

    typedef enum logic { ROW_CFG, ROW_BLOCK } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [63:0]            data;
        logic [127:0]           blk;
        bit                     known;
        logic [127:0]           want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [127:0]           s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [127:0]           m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [63:0]            i_cfg_data = '0;

    aes128_block_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: substitution tables, key registers and round keys.
    logic [7:0]   fwd_sbox [256];
    logic [7:0]   rev_sbox [256];
    logic [63:0]  key_hi, key_lo;
    logic         dec_mode;
    logic [127:0] round_key [ROUNDS + 1];

    logic [127:0] want_blocks [$];
    t_dir_row     dir_rows [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  blocks_sent = 0;
    int  dir_blocks = 0;
    int  cfg_writes = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    logic [127:0] head_blk;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p, x, y;
        p = '0;
        x = a;
        y = b;
        for (int i = 0; i < 8; i++) begin
            if (y[0]) p ^= x;
            x = xtime(x);
            y = y >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    // S-box from first principles: inverse in GF(2^8) (x^254), then the affine map.
    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = 8'h01;
        for (int i = 0; i < 254; i++) b = gf_mul(b, x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ AFFINE_C;
    endfunction

    function automatic logic [31:0] sub32(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   r;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = s[127 - 32*c - 8*j -: 8];
            for (int i = 0; i < 4; i++) begin
                r = '0;
                for (int j = 0; j < 4; j++)
                    r ^= gf_mul(a[j], inv ? MIX_INV[(j - i) & 3] : MIX_FWD[(j - i) & 3]);
                t[127 - 32*c - 8*i -: 8] = r;
            end
        end
        return t;
    endfunction

    // Byte n of the state sits at bits 127-8n; column c holds bytes 4c..4c+3.
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   v;
        int           src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                v = s[127 - 8*(4*src + r) -: 8];
                t[127 - 8*(4*c + r) -: 8] = inv ? rev_sbox[v] : fwd_sbox[v];
            end
        end
        return t;
    endfunction

    function automatic void expand_key();
        logic [31:0]  w [NWORDS];
        logic [31:0]  t;
        logic [7:0]   rc;
        logic [127:0] tmp;
        rc = RCON_INIT;
        w[0] = key_hi[63:32];
        w[1] = key_hi[31:0];
        w[2] = key_lo[63:32];
        w[3] = key_lo[31:0];
        for (int i = NK; i < NWORDS; i++) begin
            t = w[i-1];
            if (i % NK == 0) begin
                t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h000000};
                rc = xtime(rc);
            end
            w[i] = w[i-NK] ^ t;
        end
        for (int r = 0; r <= ROUNDS; r++)
            round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
        // equivalent inverse cipher: reversed schedule, middle keys through InvMixColumns
        if (dec_mode) begin
            for (int r = 0; r < (ROUNDS + 1) / 2; r++) begin
                tmp = round_key[r];
                round_key[r] = round_key[ROUNDS - r];
                round_key[ROUNDS - r] = tmp;
            end
            for (int r = 1; r < ROUNDS; r++) round_key[r] = mix_state(round_key[r], 1'b1);
        end
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        case (idx)
            CFG_KEY_HIGH: key_hi = data;
            CFG_KEY_LOW:  key_lo = data;
            CFG_DECRYPT:  dec_mode = data[0];
            default:      return;
        endcase
        expand_key();
    endfunction

    // Block and result use byte 0 in bits 127:120 here; on the bus the high half is tdata[63:0].
    function automatic logic [127:0] aes_cipher(input logic [127:0] blk);
        logic [127:0] st;
        st = blk ^ round_key[0];
        for (int rnd = 1; rnd <= ROUNDS; rnd++) begin
            st = sub_shift(st, dec_mode);
            if (rnd != ROUNDS) st = mix_state(st, dec_mode);
            st ^= round_key[rnd];
        end
        return st;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        t_dir_row row;
        row = '{ROW_CFG, idx, data, '0, 1'b0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_blk(input logic [127:0] blk, input bit known,
                                    input logic [127:0] want);
        t_dir_row row;
        row = '{ROW_BLOCK, '0, '0, blk, known, want};
        dir_rows.push_back(row);
    endfunction

    task automatic send_block(input logic [127:0] blk, input logic [127:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk[63:0], blk[127:64]};
        do @(posedge i_clk); while (!s_axis_tready);
        want_blocks.push_back(want);
        blocks_sent++;
    endtask

    // Leaves i_cfg_valid high so back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, data);
        cfg_writes++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (want_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Output side: check each accepted result, then pick tready for the next edge.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (want_blocks.size() == 0) begin
                $error("result with no block pending: %h", m_axis_tdata);
                mismatches++;
            end else begin
                head_blk = want_blocks.pop_front();
                results_seen++;
                if (m_axis_tdata[63:0] !== head_blk[127:64]) begin
                    $error("result_high: expected %h, got %h", head_blk[127:64],
                           m_axis_tdata[63:0]);
                    mismatches++;
                end
                if (m_axis_tdata[127:64] !== head_blk[63:0]) begin
                    $error("result_low: expected %h, got %h", head_blk[63:0],
                           m_axis_tdata[127:64]);
                    mismatches++;
                end
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYC;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_dir_row     row;
        logic [127:0] blk;
        logic [127:0] prev_out;
        bit           prev_cfg;

        for (int i = 0; i < 256; i++) begin
            fwd_sbox[i] = sbox_calc(8'(i));
            rev_sbox[fwd_sbox[i]] = 8'(i);
        end
        key_hi   = '0;
        key_lo   = '0;
        dec_mode = 1'b0;
        expand_key();

        // all-zero key after reset
        add_blk(128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
        add_blk({128{1'b1}}, 1'b0, '0);
        add_blk(128'h1, 1'b0, '0);
        add_blk({1'b1, 127'h0}, 1'b0, '0);
        // FIPS-197 appendix C.1 key and vector, both directions
        add_cfg(CFG_KEY_HIGH, 64'h0001020304050607);
        add_cfg(CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        add_blk(128'h00112233445566778899aabbccddeeff, 1'b1,
                128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_cfg(CFG_DECRYPT, MODE_DECRYPT);
        add_blk(128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
                128'h00112233445566778899aabbccddeeff);
        // unused index must leave the setting alone
        add_cfg(CFG_UNUSED, 64'hffffffffffffffff);
        add_blk(128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
                128'h00112233445566778899aabbccddeeff);
        // only bit 0 of the mode write counts
        add_cfg(CFG_DECRYPT, 64'hfffffffffffffffe);
        add_blk(128'h00112233445566778899aabbccddeeff, 1'b1,
                128'h69c4e0d86a7b0430d8cdb78070b4c55a);
        add_cfg(CFG_KEY_HIGH, 64'hffffffffffffffff);
        add_cfg(CFG_KEY_LOW,  64'hffffffffffffffff);
        add_blk(128'h0, 1'b0, '0);
        add_blk({128{1'b1}}, 1'b0, '0);
        add_cfg(CFG_DECRYPT, 64'hffffffffffffffff);
        add_blk(128'h0, 1'b0, '0);
        add_blk({128{1'b1}}, 1'b0, '0);
        add_cfg(CFG_KEY_HIGH, 64'h0);
        add_cfg(CFG_KEY_LOW,  64'h0);
        add_blk(128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1, 128'h0);
        add_cfg(CFG_DECRYPT, MODE_ENCRYPT);
        add_blk(128'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_cfg = 1'b0;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                if (!prev_cfg) settle();
                write_reg(row.idx, row.data);
                prev_cfg = 1'b1;
            end else begin
                if (prev_cfg) i_cfg_valid <= 1'b0;
                prev_cfg = 1'b0;
                send_block(row.blk, row.known ? row.want : aes_cipher(row.blk));
                dir_blocks++;
            end
        end

        prev_out = '0;
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
                default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
            endcase
            if (p == 0) begin
                write_reg(CFG_KEY_HIGH, 64'h0);
                write_reg(CFG_KEY_LOW, 64'h0);
            end else if (p == RAND_PHASES - 1) begin
                write_reg(CFG_KEY_HIGH, 64'hffffffffffffffff);
                write_reg(CFG_KEY_LOW, 64'hffffffffffffffff);
            end else begin
                write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
                write_reg(CFG_KEY_LOW, {$urandom, $urandom});
            end
            // mode alternates per phase; upper data bits are noise
            write_reg(CFG_DECRYPT, {$urandom, $urandom} & ~64'd1 | 64'(p % 2));
            if ($urandom_range(1)) write_reg(CFG_UNUSED, {$urandom, $urandom});
            i_cfg_valid <= 1'b0;
            // long output hold while the sender keeps offering, to back the block up
            if (p == 4) hold_req <= ~hold_req;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0: blk = '0;
                    1: blk = {128{1'b1}};
                    2: blk = 128'h1 << $urandom_range(127);
                    3: blk = prev_out;
                    default: blk = {$urandom, $urandom, $urandom, $urandom};
                endcase
                prev_out = aes_cipher(blk);
                send_block(blk, prev_out);
            end
        end

        settle();
        $display("Sent %0d blocks (%0d directed) with %0d register writes: both modes, zero and",
                 blocks_sent, dir_blocks, cfg_writes);
        $display("all-ones keys, ignored index, mode masking, idling, stalls and a long hold; %0d %s",
                 results_seen, "results checked");
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
